FILE: hw/rtl/mde_pkg.sv
// Package for the depth-first maze explorer: item types, codes and the turn function.
`timescale 1ns / 1ps
`default_nettype none

package mde_pkg;

  // Absolute headings.
  localparam logic [1:0] DIR_SOUTH = 2'd0;
  localparam logic [1:0] DIR_EAST  = 2'd1;
  localparam logic [1:0] DIR_NORTH = 2'd2;
  localparam logic [1:0] DIR_WEST  = 2'd3;

  // Turns made before driving forward.
  localparam logic [2:0] TURN_NONE        = 3'd0;
  localparam logic [2:0] TURN_LEFT        = 3'd1;
  localparam logic [2:0] TURN_RIGHT       = 3'd2;
  localparam logic [2:0] TURN_RIGHT_TWICE = 3'd3;
  localparam logic [2:0] TURN_LEFT_TWICE  = 3'd4;

  // Step outcomes.
  localparam logic [1:0] STATUS_ADVANCE = 2'd0;
  localparam logic [1:0] STATUS_BACK    = 2'd1;
  localparam logic [1:0] STATUS_GOAL    = 2'd2;
  localparam logic [1:0] STATUS_STUCK   = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_START_COL     = 2'd0;
  localparam logic [1:0] REG_START_ROW     = 2'd1;
  localparam logic [1:0] REG_START_HEADING = 2'd2;

  // Reset values of the registers.
  localparam logic [3:0] START_COL_RESET     = 4'd0;
  localparam logic [3:0] START_ROW_RESET     = 4'd0;
  localparam logic [1:0] START_HEADING_RESET = 2'd2;

  // Walls sensed at the current cell.
  typedef struct packed {
    logic wall_south;
    logic wall_east;
    logic wall_north;
    logic wall_west;
  } in_item_t;

  // One step result.
  typedef struct packed {
    logic [3:0] next_col;
    logic [3:0] next_row;
    logic [1:0] new_heading;
    logic [2:0] turn_code;
    logic [1:0] step_status;
  } out_item_t;

  // Turn needed to go from one heading to another; a half turn towards
  // west is made to the left, any other half turn to the right.
  function automatic logic [2:0] turn_for(input logic [1:0] from_dir,
                                          input logic [1:0] to_dir);
    logic [1:0] diff;
    logic [2:0] turn;
    diff = to_dir - from_dir;
    case (diff)
      2'd0: turn = TURN_NONE;
      2'd1: turn = TURN_LEFT;
      2'd3: turn = TURN_RIGHT;
      default: turn = (to_dir == DIR_WEST) ? TURN_LEFT_TWICE : TURN_RIGHT_TWICE;
    endcase
    return turn;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/maze_dfs_explorer.sv
// Top level of the depth-first maze explorer step engine.
//
//   Channel   Direction  Handshake               Payload
//   in        sink       in_valid / in_stall     mde_pkg::in_item_t  (four wall bits)
//   out       source     out_valid / out_stall   mde_pkg::out_item_t (cell, heading, turn, status)
//   config    APB slave  psel / penable / pready start_col, start_row, start_heading
//
// A step that moves runs through the states FETCH_SE and FETCH_NW, which read the neighbours'
// visited bits from the map memory (two read ports) and the parent entry from the stack memory,
// and READY, which decides and writes back. A goal or stuck step changes nothing and stays in READY.
// After reset and after every write to one of the three registers a clearing pass rewrites
// all 2**(2*ceil(log2 GRID_SIZE)) visited-map entries (256 at the default size); in_stall is high meanwhile.
// One item waits in an input register while a step is prepared; the result register holds
// a stalled transfer without blocking the next fetch.
`timescale 1ns / 1ps
`default_nettype none

module maze_dfs_explorer #(
  parameter int GRID_SIZE = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  mde_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  wire                 out_stall,
  output mde_pkg::out_item_t  out_item,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [3:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int CW        = $clog2(GRID_SIZE);
  localparam int AW        = 2 * CW;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int SW        = $clog2(CELLS);
  localparam int DW        = $clog2(CELLS + 1);
  localparam int MAP_DEPTH = 1 << AW;
  localparam int GOAL_LO   = GRID_SIZE / 2 - 1;
  localparam int GOAL_HI   = GRID_SIZE / 2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_FETCH_SE,
    ST_FETCH_NW,
    ST_READY
  } state_t;

  state_t state;

  // Configuration registers.
  logic [3:0] start_col;
  logic [3:0] start_row;
  logic [1:0] start_heading;

  // Exploration state.
  logic [CW-1:0] cur_col;
  logic [CW-1:0] cur_row;
  logic [1:0]    heading;
  logic [DW-1:0] depth;
  logic [AW-1:0] clr_addr;
  logic          vis_s;
  logic          vis_e;

  // Input register.
  logic               buf_full;
  mde_pkg::in_item_t  buf_item;

  // Memories and their ports.
  logic          vis_mem [MAP_DEPTH];
  logic          vis_we;
  logic [AW-1:0] vis_waddr;
  logic          vis_wdata;
  logic          vis_re;
  logic [AW-1:0] vis_raddr_a;
  logic [AW-1:0] vis_raddr_b;
  logic          vis_rd_a;
  logic          vis_rd_b;

  logic [AW-1:0] stk_mem [CELLS];
  logic          stk_we;
  logic [SW-1:0] stk_waddr;
  logic [AW-1:0] stk_wdata;
  logic          stk_re;
  logic [SW-1:0] stk_raddr;
  logic [AW-1:0] stk_rd;

  // Step decision.
  logic          cfg_write;
  logic          fire;
  logic [CW-1:0] seed_col;
  logic [CW-1:0] seed_row;
  logic [CW-1:0] par_col;
  logic [CW-1:0] par_row;
  logic [3:0]    avail;
  logic          is_goal;
  logic          moved;
  logic          pushed;
  logic [CW-1:0] nxt_col;
  logic [CW-1:0] nxt_row;
  logic [1:0]    nxt_heading;
  logic [2:0]    nxt_turn;
  logic [1:0]    nxt_status;
  logic [DW-1:0] depth_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign in_stall  = (state == ST_CLEAR) || buf_full;
  assign fire      = (state == ST_READY) && buf_full && (!out_valid || !out_stall);

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      mde_pkg::REG_START_COL:     prdata = {28'd0, start_col};
      mde_pkg::REG_START_ROW:     prdata = {28'd0, start_row};
      mde_pkg::REG_START_HEADING: prdata = {30'd0, start_heading};
      default:                    prdata = 32'd0;
    endcase
  end

  // Start cell, saturated to the grid.
  assign seed_col = (int'(start_col) >= GRID_SIZE) ? CW'(GRID_SIZE - 1) : CW'(start_col);
  assign seed_row = (int'(start_row) >= GRID_SIZE) ? CW'(GRID_SIZE - 1) : CW'(start_row);

  // The stack holds each cell as row above column.
  assign par_row = stk_rd[AW-1:CW];
  assign par_col = stk_rd[CW-1:0];

  // Pick the first open, in-grid, unvisited neighbour; otherwise step back to the parent.
  always_comb begin
    is_goal = ((cur_col == CW'(GOAL_LO)) || (cur_col == CW'(GOAL_HI))) &&
              ((cur_row == CW'(GOAL_LO)) || (cur_row == CW'(GOAL_HI)));
    avail[0] = !buf_item.wall_south && (cur_row != '0) && !vis_s;
    avail[1] = !buf_item.wall_east && (cur_col < CW'(GRID_SIZE - 1)) && !vis_e;
    avail[2] = !buf_item.wall_north && (cur_row < CW'(GRID_SIZE - 1)) && !vis_rd_a;
    avail[3] = !buf_item.wall_west && (cur_col != '0) && !vis_rd_b;
    if (depth >= DW'(CELLS)) begin
      avail = 4'b0000;
    end
    nxt_col     = cur_col;
    nxt_row     = cur_row;
    nxt_heading = heading;
    nxt_turn    = mde_pkg::TURN_NONE;
    nxt_status  = mde_pkg::STATUS_STUCK;
    moved       = 1'b0;
    pushed      = 1'b0;
    depth_next  = depth;
    if (is_goal) begin
      nxt_status = mde_pkg::STATUS_GOAL;
    end else if (avail != 4'b0000) begin
      moved      = 1'b1;
      pushed     = 1'b1;
      depth_next = depth + 1'b1;
      nxt_status = mde_pkg::STATUS_ADVANCE;
      if (avail[0]) begin
        nxt_row     = cur_row - 1'b1;
        nxt_heading = mde_pkg::DIR_SOUTH;
      end else if (avail[1]) begin
        nxt_col     = cur_col + 1'b1;
        nxt_heading = mde_pkg::DIR_EAST;
      end else if (avail[2]) begin
        nxt_row     = cur_row + 1'b1;
        nxt_heading = mde_pkg::DIR_NORTH;
      end else begin
        nxt_col     = cur_col - 1'b1;
        nxt_heading = mde_pkg::DIR_WEST;
      end
      nxt_turn = mde_pkg::turn_for(heading, nxt_heading);
    end else if (depth > DW'(1)) begin
      moved      = 1'b1;
      depth_next = depth - 1'b1;
      nxt_status = mde_pkg::STATUS_BACK;
      nxt_col    = par_col;
      nxt_row    = par_row;
      if (par_row < cur_row) begin
        nxt_heading = mde_pkg::DIR_SOUTH;
      end else if (par_row > cur_row) begin
        nxt_heading = mde_pkg::DIR_NORTH;
      end else if (par_col > cur_col) begin
        nxt_heading = mde_pkg::DIR_EAST;
      end else if (par_col < cur_col) begin
        nxt_heading = mde_pkg::DIR_WEST;
      end
      nxt_turn = mde_pkg::turn_for(heading, nxt_heading);
    end
  end

  // Memory port control: the clearing pass, the neighbour fetches and the write-back.
  always_comb begin
    vis_we      = 1'b0;
    vis_waddr   = {nxt_col, nxt_row};
    vis_wdata   = 1'b1;
    vis_re      = 1'b0;
    vis_raddr_a = {cur_col, cur_row - 1'b1};
    vis_raddr_b = {cur_col + 1'b1, cur_row};
    stk_we      = 1'b0;
    stk_waddr   = depth[SW-1:0];
    stk_wdata   = {nxt_row, nxt_col};
    stk_re      = 1'b0;
    stk_raddr   = SW'(depth - DW'(2));
    case (state)
      ST_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_addr;
        vis_wdata = (clr_addr == {seed_col, seed_row});
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = {seed_row, seed_col};
      end
      ST_FETCH_SE: begin
        vis_re = 1'b1;
        stk_re = 1'b1;
      end
      ST_FETCH_NW: begin
        vis_re      = 1'b1;
        vis_raddr_a = {cur_col, cur_row + 1'b1};
        vis_raddr_b = {cur_col - 1'b1, cur_row};
      end
      ST_READY: begin
        vis_we = fire && pushed;
        stk_we = fire && pushed;
      end
      default: begin
        vis_we = 1'b0;
      end
    endcase
  end

  // Visited map: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    if (vis_re) begin
      vis_rd_a <= vis_mem[vis_raddr_a];
      vis_rd_b <= vis_mem[vis_raddr_b];
    end
  end

  // Path stack: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd <= stk_mem[stk_raddr];
    end
  end

  // Sequencer, exploration state, input register and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      start_col     <= mde_pkg::START_COL_RESET;
      start_row     <= mde_pkg::START_ROW_RESET;
      start_heading <= mde_pkg::START_HEADING_RESET;
      buf_full      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (paddr[3:2])
          mde_pkg::REG_START_COL:     start_col     <= pwdata[3:0];
          mde_pkg::REG_START_ROW:     start_row     <= pwdata[3:0];
          mde_pkg::REG_START_HEADING: start_heading <= pwdata[1:0];
          default:                    start_col     <= start_col;
        endcase
        if (paddr[3:2] != 2'd3) begin
          state    <= ST_CLEAR;
          clr_addr <= '0;
        end
      end else begin
        case (state)
          ST_CLEAR: begin
            cur_col  <= seed_col;
            cur_row  <= seed_row;
            heading  <= start_heading;
            depth    <= DW'(1);
            clr_addr <= clr_addr + 1'b1;
            if (clr_addr == '1) begin
              state <= ST_FETCH_SE;
            end
          end
          ST_FETCH_SE: begin
            state <= ST_FETCH_NW;
          end
          ST_FETCH_NW: begin
            vis_s <= vis_rd_a;
            vis_e <= vis_rd_b;
            state <= ST_READY;
          end
          ST_READY: begin
            if (fire && moved) begin
              cur_col <= nxt_col;
              cur_row <= nxt_row;
              heading <= nxt_heading;
              depth   <= depth_next;
              state   <= ST_FETCH_SE;
            end
          end
          default: begin
            state <= ST_CLEAR;
          end
        endcase
      end

      // Input transfer into the waiting register.
      if (in_valid && !in_stall) begin
        buf_item <= in_item;
        buf_full <= 1'b1;
      end else if (fire) begin
        buf_full <= 1'b0;
      end

      // Result register.
      if (fire) begin
        out_valid            <= 1'b1;
        out_item.next_col    <= 4'(nxt_col);
        out_item.next_row    <= 4'(nxt_row);
        out_item.new_heading <= nxt_heading;
        out_item.turn_code   <= nxt_turn;
        out_item.step_status <= nxt_status;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mde_checker.sv
// Port-level checker for the maze explorer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mde_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 in_stall,
  input wire                 out_valid,
  input wire                 out_stall,
  input mde_pkg::out_item_t  out_item,
  input wire                 psel,
  input wire                 penable,
  input wire                 pwrite,
  input wire [3:0]           paddr
);

  // A stalled result stays put.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Only the five defined turn codes are produced.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.turn_code <= mde_pkg::TURN_LEFT_TWICE)
    else $error("undefined turn code");

  // A step that stays in place never turns.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.step_status == mde_pkg::STATUS_GOAL ||
                  out_item.step_status == mde_pkg::STATUS_STUCK)
    |-> out_item.turn_code == mde_pkg::TURN_NONE)
    else $error("turn reported without a move");

  // A write to one of the three registers starts the clearing pass, which refuses input.
  assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[3:2] != 2'd3 |=> in_stall)
    else $error("input taken during the clearing pass");

  // Input is refused in the first cycle after reset.
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("input taken straight after reset");

endmodule

bind maze_dfs_explorer mde_checker u_mde_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr)
);

`default_nettype wire

FILE: tb/tb.sv
// Testbench for the depth-first maze explorer: wall sequences checked against a step predictor.
`timescale 1ns / 1ps

module tb;
  import mde_pkg::*;

  localparam int GRID = 16;
  localparam int CELL_COUNT = GRID * GRID;
  localparam logic [3:0] CENTRE_LO = 4'd7;
  localparam logic [3:0] CENTRE_HI = 4'd8;
  localparam logic [3:0] GRID_LAST = 4'd15;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam in_item_t ALL_WALLS = '1;
  localparam in_item_t NO_WALLS = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Register copies and exploration state of the predictor.
  logic [3:0] start_col_q;
  logic [3:0] start_row_q;
  logic [1:0] start_heading_q;
  logic [3:0] here_col;
  logic [3:0] here_row;
  logic [1:0] facing;
  logic       visited [CELL_COUNT];
  logic [7:0] trail [CELL_COUNT];
  int         trail_depth;

  out_item_t  pending_steps [$];
  out_item_t  oldest_step;
  int         error_count = 0;
  int         sender_idle_pct = 0;
  int         stall_pct = 0;

  maze_dfs_explorer #(
    .GRID_SIZE(GRID)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Generous overall limit on the run.
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // The receiver stalls at random, changing only at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic logic is_centre(input logic [3:0] c, input logic [3:0] r);
    return (c == CENTRE_LO || c == CENTRE_HI) && (r == CENTRE_LO || r == CENTRE_HI);
  endfunction

  // Neighbouring cell in a given direction; returns 0 when it lies off the grid.
  function automatic logic step_neighbour(input logic [3:0] c, input logic [3:0] r,
                                          input logic [1:0] d,
                                          output logic [3:0] nc, output logic [3:0] nr);
    logic in_grid;
    nc = c;
    nr = r;
    in_grid = 1'b0;
    case (d)
      DIR_SOUTH: begin
        nr = r - 4'd1;
        in_grid = (r != 4'd0);
      end
      DIR_EAST: begin
        nc = c + 4'd1;
        in_grid = (c != GRID_LAST);
      end
      DIR_NORTH: begin
        nr = r + 4'd1;
        in_grid = (r != GRID_LAST);
      end
      default: begin
        nc = c - 4'd1;
        in_grid = (c != 4'd0);
      end
    endcase
    return in_grid;
  endfunction

  // A half turn towards west goes left, every other half turn right.
  function automatic logic [2:0] turn_between(input logic [1:0] from_dir,
                                              input logic [1:0] to_dir);
    logic [1:0] delta;
    delta = to_dir - from_dir;
    if (delta == 2'd0) return TURN_NONE;
    if (delta == 2'd1) return TURN_LEFT;
    if (delta == 2'd3) return TURN_RIGHT;
    if (to_dir == DIR_WEST) return TURN_LEFT_TWICE;
    return TURN_RIGHT_TWICE;
  endfunction

  task automatic reseed_exploration();
    here_col = start_col_q;
    here_row = start_row_q;
    facing = start_heading_q;
    foreach (visited[i]) visited[i] = 1'b0;
    visited[{here_col, here_row}] = 1'b1;
    trail[0] = {here_col, here_row};
    trail_depth = 1;
  endtask

  // Every register write re-seeds the exploration; the spare index does nothing.
  task automatic apply_register(input logic [1:0] idx, input logic [31:0] value);
    case (idx)
      REG_START_COL:     start_col_q = value[3:0];
      REG_START_ROW:     start_row_q = value[3:0];
      REG_START_HEADING: start_heading_q = value[1:0];
      default:           return;
    endcase
    reseed_exploration();
  endtask

  // One exploration step: advance to the first free neighbour, else backtrack.
  task automatic predict_step(input in_item_t w, output out_item_t r);
    logic [3:0] blocked;
    logic [3:0] nc;
    logic [3:0] nr;
    logic [1:0] d;
    logic [1:0] back_dir;
    logic [7:0] parent;
    logic       moved;
    r.next_col = here_col;
    r.next_row = here_row;
    r.new_heading = facing;
    r.turn_code = TURN_NONE;
    r.step_status = STATUS_GOAL;
    if (is_centre(here_col, here_row)) return;
    blocked = {w.wall_west, w.wall_north, w.wall_east, w.wall_south};
    moved = 1'b0;
    for (int k = 0; k < 4 && !moved; k++) begin
      d = k[1:0];
      if (!blocked[d] && step_neighbour(here_col, here_row, d, nc, nr) &&
          !visited[{nc, nr}] && trail_depth < CELL_COUNT) begin
        trail[trail_depth] = {nc, nr};
        trail_depth++;
        visited[{nc, nr}] = 1'b1;
        r.turn_code = turn_between(facing, d);
        facing = d;
        here_col = nc;
        here_row = nr;
        moved = 1'b1;
      end
    end
    if (moved) begin
      r.step_status = STATUS_ADVANCE;
    end else if (trail_depth <= 1) begin
      r.step_status = STATUS_STUCK;
    end else begin
      trail_depth--;
      parent = trail[trail_depth - 1];
      nc = parent[7:4];
      nr = parent[3:0];
      // An identical cell leaves the heading alone.
      if (nr != here_row || nc != here_col) begin
        if (nr < here_row) back_dir = DIR_SOUTH;
        else if (nr > here_row) back_dir = DIR_NORTH;
        else if (nc > here_col) back_dir = DIR_EAST;
        else back_dir = DIR_WEST;
        r.turn_code = turn_between(facing, back_dir);
        facing = back_dir;
      end
      here_col = nc;
      here_row = nr;
      r.step_status = STATUS_BACK;
    end
    r.next_col = here_col;
    r.next_row = here_row;
    r.new_heading = facing;
  endtask

  // Each result transfer is compared with the oldest predicted step.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_steps.size() == 0) begin
        report_mismatch("result with no step waiting", out_item, 0);
      end else begin
        oldest_step = pending_steps.pop_front();
        if (out_item.next_col !== oldest_step.next_col)
          report_mismatch("next_col", out_item.next_col, oldest_step.next_col);
        if (out_item.next_row !== oldest_step.next_row)
          report_mismatch("next_row", out_item.next_row, oldest_step.next_row);
        if (out_item.new_heading !== oldest_step.new_heading)
          report_mismatch("new_heading", out_item.new_heading, oldest_step.new_heading);
        if (out_item.turn_code !== oldest_step.turn_code)
          report_mismatch("turn_code", out_item.turn_code, oldest_step.turn_code);
        if (out_item.step_status !== oldest_step.step_status)
          report_mismatch("step_status", out_item.step_status, oldest_step.step_status);
      end
    end
  end

  // Sends one wall reading, with a random gap first; returns the predicted status.
  task automatic send_walls(input in_item_t w, output logic [1:0] status);
    out_item_t step;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_step(w, step);
    pending_steps.push_back(step);
    status = step.step_status;
    @(negedge clk);
  endtask

  // Called at a falling edge; returns at a falling edge once every result is in.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    apply_register(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [31:0] want,
                           input logic [31:0] mask);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if ((prdata & mask) !== want) report_mismatch("register readback", prdata & mask, want);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_all_regs();
    check_reg(REG_START_COL, {28'd0, start_col_q}, 32'hF);
    check_reg(REG_START_ROW, {28'd0, start_row_q}, 32'hF);
    check_reg(REG_START_HEADING, {30'd0, start_heading_q}, 32'h3);
  endtask

  function automatic in_item_t walls_except(input logic [1:0] d);
    in_item_t w;
    w = ALL_WALLS;
    case (d)
      DIR_SOUTH: w.wall_south = 1'b0;
      DIR_EAST:  w.wall_east = 1'b0;
      DIR_NORTH: w.wall_north = 1'b0;
      default:   w.wall_west = 1'b0;
    endcase
    return w;
  endfunction

  // Random walls; when shielded, openings into the centre are all closed so
  // that the exploration runs deep before it reaches the goal.
  function automatic in_item_t pick_walls(input int wall_pct, input logic shield);
    in_item_t   w;
    logic [3:0] blocked;
    logic [3:0] nc;
    logic [3:0] nr;
    for (int d = 0; d < 4; d++) begin
      blocked[d] = ($urandom_range(99) < wall_pct);
      if (shield && step_neighbour(here_col, here_row, d[1:0], nc, nr) && is_centre(nc, nr))
        blocked[d] = 1'b1;
    end
    w.wall_south = blocked[DIR_SOUTH];
    w.wall_east = blocked[DIR_EAST];
    w.wall_north = blocked[DIR_NORTH];
    w.wall_west = blocked[DIR_WEST];
    return w;
  endfunction

  function automatic logic [3:0] pick_coord();
    case ($urandom_range(7))
      0:       return 4'd0;
      1:       return GRID_LAST;
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  // Re-seeds from a random start, writing one or more registers with junk above the field.
  task automatic choose_start();
    int          which;
    logic [31:0] junk;
    which = $urandom_range(1, 7);
    junk = $urandom();
    if (which[0]) write_reg(REG_START_COL, {junk[31:4], pick_coord()});
    if (which[1]) write_reg(REG_START_ROW, {junk[31:4], pick_coord()});
    if (which[2]) write_reg(REG_START_HEADING, {junk[31:2], 2'($urandom_range(3))});
    check_all_regs();
  endtask

  // Default start at the south-west corner facing north: stuck, advance and both half turns.
  task automatic test_default_start();
    logic [1:0] s;
    check_all_regs();
    send_walls(ALL_WALLS, s);
    send_walls(NO_WALLS, s);
    send_walls(ALL_WALLS, s);
    send_walls(ALL_WALLS, s);
    send_walls(walls_except(DIR_NORTH), s);
    send_walls(ALL_WALLS, s);
    wait_idle();
  endtask

  // Starts in the corners, with openings that lead off the grid.
  task automatic test_corner_starts();
    logic [1:0] s;
    write_reg(REG_START_COL, {28'd0, GRID_LAST});
    write_reg(REG_START_ROW, {28'd0, GRID_LAST});
    write_reg(REG_START_HEADING, {30'd0, DIR_SOUTH});
    send_walls(NO_WALLS, s);
    send_walls(walls_except(DIR_EAST), s);
    send_walls(NO_WALLS, s);
    write_reg(REG_START_COL, 32'd0);
    write_reg(REG_START_HEADING, {30'd0, DIR_WEST});
    send_walls(walls_except(DIR_WEST), s);
    send_walls(NO_WALLS, s);
    write_reg(REG_START_COL, {28'd0, GRID_LAST});
    write_reg(REG_START_ROW, 32'd0);
    write_reg(REG_START_HEADING, {30'd0, DIR_EAST});
    send_walls(NO_WALLS, s);
    wait_idle();
  endtask

  // Walking into the centre, and starting there.
  task automatic test_goal_cells();
    logic [1:0] s;
    write_reg(REG_START_COL, {28'd0, CENTRE_LO});
    write_reg(REG_START_ROW, {28'd0, CENTRE_LO - 4'd1});
    write_reg(REG_START_HEADING, {30'd0, DIR_NORTH});
    send_walls(walls_except(DIR_NORTH), s);
    send_walls(NO_WALLS, s);
    send_walls(ALL_WALLS, s);
    write_reg(REG_START_COL, {28'd0, CENTRE_HI});
    write_reg(REG_START_ROW, {28'd0, CENTRE_HI});
    send_walls(NO_WALLS, s);
    write_reg(REG_START_ROW, {28'd0, CENTRE_HI + 4'd1});
    write_reg(REG_START_HEADING, {30'd0, DIR_EAST});
    send_walls(walls_except(DIR_SOUTH), s);
    send_walls(NO_WALLS, s);
    wait_idle();
  endtask

  // A write beyond the register list leaves the exploration where it is.
  task automatic test_spare_register();
    logic [1:0] s;
    write_reg(REG_START_COL, 32'd3);
    write_reg(REG_START_ROW, 32'd3);
    write_reg(REG_START_HEADING, {30'd0, DIR_NORTH});
    send_walls(NO_WALLS, s);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_walls(NO_WALLS, s);
    wait_idle();
    check_all_regs();
  endtask

  // Random explorations from random starts, each cut short once it has settled.
  task automatic test_random_exploration(input int items, input int idle_pct,
                                         input int stall_p);
    int         sent;
    int         run_left;
    int         settled;
    int         wall_pct;
    logic [1:0] s;
    sender_idle_pct = idle_pct;
    stall_pct = stall_p;
    sent = 0;
    while (sent < items) begin
      choose_start();
      run_left = $urandom_range(20, 90);
      wall_pct = $urandom_range(15, 60);
      settled = 0;
      while (sent < items && run_left > 0 && settled < 3) begin
        send_walls(pick_walls(wall_pct, $urandom_range(99) < 85), s);
        sent++;
        run_left--;
        if (s == STATUS_GOAL || s == STATUS_STUCK) settled++;
      end
    end
    wait_idle();
  endtask

  initial begin
    start_col_q = START_COL_RESET;
    start_row_q = START_ROW_RESET;
    start_heading_q = START_HEADING_RESET;
    reseed_exploration();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_start();
    test_corner_starts();
    test_goal_cells();
    test_spare_register();
    test_random_exploration(345, 0, 0);
    test_random_exploration(345, 86, 0);
    test_random_exploration(345, 0, 86);
    test_random_exploration(345, 36, 36);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/mde_pkg.sv
hw/rtl/maze_dfs_explorer.sv
hw/rtl/mde_checker.sv
tb/tb.sv
